// ===== src/speed_ramp_with_brake_cap_top_defines.svh =====
// ----------------------------------------------------------------------------
// Speed ramp assertion macros
// Shared property wrappers for the speed ramp block checks.
// ----------------------------------------------------------------------------
`ifndef SPEED_RAMP_WITH_BRAKE_CAP_TOP_DEFINES_SVH
`define SPEED_RAMP_WITH_BRAKE_CAP_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SRBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/srbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Speed ramp package
// Constants, control word layout and microcode program of the speed ramp.
// ----------------------------------------------------------------------------
package srbc_pkg;

    localparam int INTERVAL_FRAC_BITS = 24;
    localparam int SPEED_W = 32;
    localparam int OP_W = 2;
    localparam int PC_W = 4;
    localparam int SQ_CNT_W = 5;

    // request opcodes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_CUR = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_TGT = 2'd2;
    localparam logic [OP_W-1:0] OP_BRAKE   = 2'd3;

    // datapath micro-operations
    localparam logic [3:0] UOP_NOP     = 4'd0;
    localparam logic [3:0] UOP_MUL     = 4'd1;
    localparam logic [3:0] UOP_TICK    = 4'd2;
    localparam logic [3:0] UOP_SET_CUR = 4'd3;
    localparam logic [3:0] UOP_SET_TGT = 4'd4;
    localparam logic [3:0] UOP_SQ_INIT = 4'd5;
    localparam logic [3:0] UOP_SQ_STEP = 4'd6;
    localparam logic [3:0] UOP_BRAKE   = 4'd7;
    localparam logic [3:0] UOP_EMIT    = 4'd8;

    // sequencing conditions
    localparam logic [2:0] COND_NEXT     = 3'd0;
    localparam logic [2:0] COND_GOTO     = 3'd1;
    localparam logic [2:0] COND_ACCEPT   = 3'd2;
    localparam logic [2:0] COND_DISPATCH = 3'd3;
    localparam logic [2:0] COND_LOOP     = 3'd4;
    localparam logic [2:0] COND_OUT      = 3'd5;

    // program addresses
    localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
    localparam logic [PC_W-1:0] PC_TICK_MUL = 4'd2;
    localparam logic [PC_W-1:0] PC_TICK_UPD = 4'd3;
    localparam logic [PC_W-1:0] PC_SET_CUR  = 4'd4;
    localparam logic [PC_W-1:0] PC_SET_TGT  = 4'd5;
    localparam logic [PC_W-1:0] PC_BRK_MUL  = 4'd6;
    localparam logic [PC_W-1:0] PC_SQ_INIT  = 4'd7;
    localparam logic [PC_W-1:0] PC_SQ_STEP  = 4'd8;
    localparam logic [PC_W-1:0] PC_BRK_UPD  = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd10;

    typedef struct packed {
        logic [3:0]      uop;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            PC_FETCH:    w = '{UOP_NOP,     COND_ACCEPT,   PC_DISPATCH};
            PC_DISPATCH: w = '{UOP_NOP,     COND_DISPATCH, PC_FETCH};
            PC_TICK_MUL: w = '{UOP_MUL,     COND_NEXT,     PC_FETCH};
            PC_TICK_UPD: w = '{UOP_TICK,    COND_GOTO,     PC_EMIT};
            PC_SET_CUR:  w = '{UOP_SET_CUR, COND_GOTO,     PC_EMIT};
            PC_SET_TGT:  w = '{UOP_SET_TGT, COND_GOTO,     PC_EMIT};
            PC_BRK_MUL:  w = '{UOP_MUL,     COND_NEXT,     PC_FETCH};
            PC_SQ_INIT:  w = '{UOP_SQ_INIT, COND_NEXT,     PC_FETCH};
            PC_SQ_STEP:  w = '{UOP_SQ_STEP, COND_LOOP,     PC_FETCH};
            PC_BRK_UPD:  w = '{UOP_BRAKE,   COND_NEXT,     PC_FETCH};
            PC_EMIT:     w = '{UOP_EMIT,    COND_OUT,      PC_FETCH};
            default:     w = '{UOP_NOP,     COND_GOTO,     PC_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] dispatch_pc(input logic [OP_W-1:0] op);
        logic [PC_W-1:0] pc;
        case (op)
            OP_TICK:    pc = PC_TICK_MUL;
            OP_SET_CUR: pc = PC_SET_CUR;
            OP_SET_TGT: pc = PC_SET_TGT;
            OP_BRAKE:   pc = PC_BRK_MUL;
            default:    pc = PC_FETCH;
        endcase
        return pc;
    endfunction

endpackage

// ===== src/speed_ramp_with_brake_cap_top.sv =====
// Sequence: a tick passes through dispatch, multiply, update and emit steps; a speed or
// target write through dispatch, write and emit; a brake request through dispatch, multiply,
// the 32-step square root loop, update and emit. The emit step waits while the output register
// is full; a new request is taken once the previous result is in the output register.
// Reset: rst_n clears speeds and acceleration to zero, sets complete, empties output.
// ----------------------------------------------------------------------------
// Speed ramp with braking-distance cap
// Microcoded slew limiter for Q16.16 speeds with a serial square root unit.
// ----------------------------------------------------------------------------
`include "speed_ramp_with_brake_cap_top_defines.svh"

module speed_ramp_with_brake_cap_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel (max acceleration)
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [31:0]                         cfg_data,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [srbc_pkg::OP_W-1:0]           op,
    input  logic signed [srbc_pkg::SPEED_W-1:0] value_in,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [srbc_pkg::SPEED_W-1:0] current_speed_out,
    output logic signed [srbc_pkg::SPEED_W-1:0] target_speed_out,
    output logic                                complete_out
);
    import srbc_pkg::*;

    // ------------------------------------------------------------------
    // Sequencer: the step counter addresses the microcode ROM; each
    // control word selects one datapath action and how to advance.
    // ------------------------------------------------------------------
    logic [PC_W-1:0]     pc_reg, pc_next;
    ctrl_word_t          cw;

    // architectural state
    logic [31:0]         accel_reg;
    logic [SPEED_W-1:0]  cur_reg, cur_next;
    logic [SPEED_W-1:0]  tgt_reg, tgt_next;
    logic                done_reg, done_next;

    // request latch and working registers (payload, no reset)
    logic [OP_W-1:0]     op_reg;
    logic [SPEED_W-1:0]  val_reg;
    logic [62:0]         prod_reg;
    logic [32:0]         diff_reg;
    logic [63:0]         rad_reg;
    logic [34:0]         rem_reg;
    logic [31:0]         root_reg;
    logic [SQ_CNT_W-1:0] sq_cnt_reg;

    // output register
    logic                out_valid_reg;
    logic [SPEED_W-1:0]  out_cur_reg;
    logic [SPEED_W-1:0]  out_tgt_reg;
    logic                out_done_reg;

    logic                in_fire;
    logic                out_free;
    logic                out_load;

    // datapath intermediates
    logic [30:0]         mul_opnd;
    logic [63:0]         step64;
    logic [32:0]         gap;
    logic [32:0]         step33;
    logic [33:0]         cur_ext;
    logic [33:0]         ramp_sum;
    logic [SPEED_W-1:0]  ramp_sat;
    logic [34:0]         rem_sh;
    logic [34:0]         trial;
    logic                trial_ok;
    logic                cap_ok;

    assign cw        = ucode_rom(pc_reg);
    assign cfg_ready = 1'b1;
    assign in_ready  = (pc_reg == PC_FETCH);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (cw.uop == UOP_EMIT) && out_free;

    assign out_valid         = out_valid_reg;
    assign current_speed_out = out_cur_reg;
    assign target_speed_out  = out_tgt_reg;
    assign complete_out      = out_done_reg;

    // Advance the step counter.
    always_comb
    begin
        pc_next = pc_reg;
        case (cw.cond)
            COND_NEXT:     pc_next = pc_reg + 1'b1;
            COND_GOTO:     pc_next = cw.target;
            COND_ACCEPT:   pc_next = in_fire ? cw.target : pc_reg;
            COND_DISPATCH: pc_next = dispatch_pc(op_reg);
            COND_LOOP:     pc_next = (sq_cnt_reg == '0) ? pc_reg + 1'b1 : pc_reg;
            COND_OUT:      pc_next = out_free ? cw.target : pc_reg;
            default:       pc_next = PC_FETCH;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    // Clamp negative interval or distance to zero.
    assign mul_opnd = val_reg[31] ? 31'd0 : val_reg[30:0];

    // Tick: step is accel * interval with the interval fraction dropped.
    assign step64   = 64'(prod_reg >> INTERVAL_FRAC_BITS);
    assign gap      = diff_reg[32] ? (33'd0 - diff_reg) : diff_reg;
    // When a partial step is taken, step <= gap < 2^33.
    assign step33   = step64[32:0];
    assign cur_ext  = {{2{cur_reg[31]}}, cur_reg};
    assign ramp_sum = diff_reg[32] ? (cur_ext - {1'b0, step33})
                                   : (cur_ext + {1'b0, step33});

    // Saturate to the signed 32-bit range.
    always_comb
    begin
        if (!ramp_sum[33] && (ramp_sum[32:31] != 2'b00))
        begin
            ramp_sat = 32'h7FFF_FFFF;
        end
        else if (ramp_sum[33] && (ramp_sum[32:31] != 2'b11))
        begin
            ramp_sat = 32'h8000_0000;
        end
        else
        begin
            ramp_sat = ramp_sum[31:0];
        end
    end

    // One digit of the restoring square root per step.
    assign rem_sh   = {rem_reg[32:0], rad_reg[63:62]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign trial_ok = (rem_sh >= trial);

    // Brake cap applies only below the positive limit and below the target.
    assign cap_ok = (root_reg < 32'h7FFF_FFFF)
                 && ($signed({1'b0, root_reg}) < $signed({tgt_reg[31], tgt_reg}));

    // Next architectural state.
    always_comb
    begin
        cur_next  = cur_reg;
        tgt_next  = tgt_reg;
        done_next = done_reg;
        case (cw.uop)
            UOP_TICK:
            begin
                // Hold a completed ramp; snap when the gap is below one step.
                if (!done_reg)
                begin
                    if (64'(gap) < step64)
                    begin
                        cur_next  = tgt_reg;
                        done_next = 1'b1;
                    end
                    else if (diff_reg != '0)
                    begin
                        cur_next = ramp_sat;
                    end
                end
            end
            UOP_SET_CUR:
            begin
                if (cur_reg != val_reg)
                begin
                    cur_next  = val_reg;
                    done_next = 1'b0;
                end
            end
            UOP_SET_TGT:
            begin
                if (tgt_reg != val_reg)
                begin
                    tgt_next  = val_reg;
                    done_next = 1'b0;
                end
            end
            UOP_BRAKE:
            begin
                if (cap_ok)
                begin
                    tgt_next  = root_reg;
                    done_next = 1'b0;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_FETCH;
            accel_reg     <= '0;
            cur_reg       <= '0;
            tgt_reg       <= '0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            cur_reg  <= cur_next;
            tgt_reg  <= tgt_next;
            done_reg <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                accel_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and output payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= op;
            val_reg <= value_in;
        end
        case (cw.uop)
            UOP_MUL:
            begin
                prod_reg <= 63'(accel_reg) * 63'(mul_opnd);
                diff_reg <= {tgt_reg[31], tgt_reg} - {cur_reg[31], cur_reg};
            end
            UOP_SQ_INIT:
            begin
                // Radicand is 2 * accel * distance.
                rad_reg    <= {prod_reg, 1'b0};
                rem_reg    <= '0;
                root_reg   <= '0;
                sq_cnt_reg <= SQ_CNT_W'(31);
            end
            UOP_SQ_STEP:
            begin
                rad_reg    <= {rad_reg[61:0], 2'b00};
                rem_reg    <= trial_ok ? (rem_sh - trial) : rem_sh;
                root_reg   <= {root_reg[30:0], trial_ok};
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
            end
            default:
            begin
                rad_reg <= rad_reg;
            end
        endcase
        if (out_load)
        begin
            out_cur_reg  <= cur_reg;
            out_tgt_reg  <= tgt_reg;
            out_done_reg <= done_reg;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SRBC_ASSERT_NOW(a_done_means_equal, done_reg, cur_reg == tgt_reg,
        "complete flag set while speeds differ")
    `SRBC_ASSERT_NEXT(a_accept_dispatch, in_fire, pc_reg == PC_DISPATCH,
        "accepted request did not reach dispatch")
    `SRBC_ASSERT_NEXT(a_sqrt_exit, (pc_reg == PC_SQ_STEP) && (sq_cnt_reg == '0),
        pc_reg == PC_BRK_UPD, "square root loop did not exit on last digit")

endmodule

// ===== verif/ramp_monitor.sv =====
// ----------------------------------------------------------------------------
// Speed ramp monitor
// Watches the configuration, request and result channels of the speed ramp,
// tracks the ramp state on its own and compares every result field by field.
// ----------------------------------------------------------------------------
module ramp_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [31:0]                         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [srbc_pkg::OP_W-1:0]           op,
    input  logic signed [srbc_pkg::SPEED_W-1:0] value_in,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [srbc_pkg::SPEED_W-1:0] current_speed_out,
    input  logic signed [srbc_pkg::SPEED_W-1:0] target_speed_out,
    input  logic                                complete_out,
    output int                                  pending,
    output int                                  failures
);
    import srbc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SPEED_W-1:0] cur;
        logic signed [SPEED_W-1:0] tgt;
        logic                      done;
    } ramp_state_t;

    logic [31:0] accel;
    ramp_state_t ramp;
    ramp_state_t ramp_due[$];
    ramp_state_t seen;

    initial
    begin
        pending  = 0;
        failures = 0;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = r | (64'd1 << i);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] clamp_speed(input logic signed [63:0] v);
        if (v > $signed(64'h0000_0000_7FFF_FFFF))
            return 32'h7FFF_FFFF;
        else if (v < $signed(64'hFFFF_FFFF_8000_0000))
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // One request applied to the ramp state.
    function automatic ramp_state_t advance_ramp(input ramp_state_t s, input logic [31:0] a,
                                                 input logic [OP_W-1:0] code,
                                                 input logic signed [SPEED_W-1:0] v);
        logic [63:0]        arg;
        logic [63:0]        step;
        logic [63:0]        gap;
        logic [63:0]        root;
        logic signed [63:0] cur_x;
        logic signed [63:0] tgt_x;
        logic signed [63:0] diff;
        arg   = v[31] ? 64'd0 : {32'd0, v};
        cur_x = $signed({{32{s.cur[31]}}, s.cur});
        tgt_x = $signed({{32{s.tgt[31]}}, s.tgt});
        case (code)
            OP_TICK:
            begin
                if (!s.done)
                begin
                    step = ({32'd0, a} * arg) >> INTERVAL_FRAC_BITS;
                    diff = tgt_x - cur_x;
                    gap  = diff[63] ? (~diff + 64'd1) : diff;
                    if (gap < step)
                    begin
                        s.cur  = s.tgt;
                        s.done = 1'b1;
                    end
                    else if (diff > 0)
                        s.cur = clamp_speed(cur_x + $signed(step));
                    else if (diff < 0)
                        s.cur = clamp_speed(cur_x - $signed(step));
                end
            end
            OP_SET_CUR:
            begin
                if (s.cur != v)
                begin
                    s.cur  = v;
                    s.done = 1'b0;
                end
            end
            OP_SET_TGT:
            begin
                if (s.tgt != v)
                begin
                    s.tgt  = v;
                    s.done = 1'b0;
                end
            end
            default:
            begin
                root = floor_sqrt(({32'd0, a} * arg) << 1);
                if (root < 64'h7FFF_FFFF && $signed(root) < tgt_x && s.tgt != root[31:0])
                begin
                    s.tgt  = root[31:0];
                    s.done = 1'b0;
                end
            end
        endcase
        return s;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel     = '0;
            ramp.cur  = '0;
            ramp.tgt  = '0;
            ramp.done = 1'b1;
            ramp_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                accel = cfg_data;
            // retire the oldest result before queuing a new request
            if (out_valid && out_ready)
            begin
                if (ramp_due.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("result with no request waiting: cur %0d tgt %0d done %0b",
                                 current_speed_out, target_speed_out, complete_out);
                end
                else
                begin
                    seen = ramp_due.pop_front();
                    compare_field("current_speed_out", seen.cur, current_speed_out);
                    compare_field("target_speed_out", seen.tgt, target_speed_out);
                    compare_field("complete_out", {31'd0, seen.done}, {31'd0, complete_out});
                end
            end
            if (in_valid && in_ready)
            begin
                ramp = advance_ramp(ramp, accel, op, value_in);
                ramp_due.push_back(ramp);
            end
        end
        pending = ramp_due.size();
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Speed ramp testbench
// Drives tick, speed, target and brake requests into the speed ramp under
// several acceleration settings and idle patterns; the monitor checks results.
// ----------------------------------------------------------------------------
module tb;
    import srbc_pkg::*;

    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 175;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 60;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [31:0]               cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [OP_W-1:0]           op;
    logic signed [SPEED_W-1:0] value_in;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [SPEED_W-1:0] current_speed_out;
    logic signed [SPEED_W-1:0] target_speed_out;
    logic                      complete_out;

    int pending;
    int failures;
    int cycles;
    int sent;
    int send_idle_pct;
    int recv_idle_pct;

    // remember the last speeds sent, so some requests repeat them unchanged
    logic [31:0] last_target;
    logic [31:0] last_speed;

    speed_ramp_with_brake_cap_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .value_in          (value_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .current_speed_out (current_speed_out),
        .target_speed_out  (target_speed_out),
        .complete_out      (complete_out)
    );

    ramp_monitor monitor (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .value_in          (value_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .current_speed_out (current_speed_out),
        .target_speed_out  (target_speed_out),
        .complete_out      (complete_out),
        .pending           (pending),
        .failures          (failures)
    );

    // 20 time unit clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Guard against a hung handshake: stop the run at a generous cycle count.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the result side at random; the idle share changes per phase.
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Pick a speed: extremes, a repeat of the last value, small values near zero,
    // or anything in the signed range.
    function automatic logic [31:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return last_target;
            3:       return last_speed;
            4, 5:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    // Pick a tick interval: mostly short so that ramps take several ticks.
    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom() | 32'h8000_0000;
            2:       return $urandom();
            3:       return $urandom_range(0, 32'h0100_0000);
            default: return $urandom_range(0, 32'h0040_0000);
        endcase
    endfunction

    // Pick a braking distance, with negative and zero distances now and then.
    function automatic logic [31:0] pick_distance();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom() | 32'h8000_0000;
            2:       return $urandom();
            3, 4:    return $urandom_range(0, 32'h0001_0000);
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    // Send one request. Idle the sender cycle by cycle at its idle share,
    // then hold the payload until the request is taken. Returns at a falling edge.
    task automatic push_request(input logic [OP_W-1:0] code, input logic [31:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        op       = code;
        value_in = v;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (code == OP_SET_TGT)
            last_target = v;
        if (code == OP_SET_CUR)
            last_speed = v;
        sent++;
    endtask

    // Write the acceleration register once the ramp has drained every result.
    task automatic write_accel(input logic [31:0] a);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = a;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random traffic. Most of it is well-formed ramps: a new target (sometimes a
    // new current speed first), a run of ticks, and now and then a brake cap
    // followed by more ticks. The rest is noise with any op and any value.
    task automatic run_segment(input int count);
        int start;
        start = sent;
        while (sent - start < count)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_request(OP_SET_CUR, pick_speed());
                push_request(OP_SET_TGT, pick_speed());
                repeat ($urandom_range(1, 6))
                    push_request(OP_TICK, pick_interval());
                if ($urandom_range(0, 2) == 0)
                begin
                    push_request(OP_BRAKE, pick_distance());
                    repeat ($urandom_range(1, 4))
                        push_request(OP_TICK, pick_interval());
                end
            end
            else
                push_request(OP_W'($urandom_range(0, 3)), $urandom());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        op            = OP_TICK;
        value_in      = '0;
        out_ready     = 1'b0;
        cycles        = 0;
        sent          = 0;
        last_target   = '0;
        last_speed    = '0;
        // sender idles lightly, receiver heavily
        send_idle_pct = 24;
        recv_idle_pct = 79;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests at a moderate acceleration.
        write_accel(32'h0010_0000);
        push_request(OP_TICK, 32'd0);             // complete ramp ignores the tick
        push_request(OP_SET_TGT, 32'd0);          // same target keeps the flag set
        push_request(OP_SET_CUR, 32'd0);          // same speed keeps the flag set
        push_request(OP_SET_TGT, 32'h7FFF_FFFF);
        push_request(OP_TICK, 32'd0);             // zero step leaves the ramp open
        push_request(OP_TICK, 32'h8000_0000);     // negative interval acts as zero
        push_request(OP_TICK, 32'h7FFF_FFFF);
        push_request(OP_SET_CUR, 32'h8000_0000);
        push_request(OP_TICK, 32'h7FFF_FFFF);
        push_request(OP_BRAKE, 32'h8000_0000);    // negative distance caps to zero
        push_request(OP_BRAKE, 32'h7FFF_FFFF);    // cap above target, no change
        push_request(OP_SET_TGT, 32'hFFFF_FFFB);
        push_request(OP_BRAKE, 32'd0);            // zero cap above a negative target

        // Full-scale acceleration.
        write_accel(32'hFFFF_FFFF);
        push_request(OP_SET_TGT, 32'h7FFF_FFFF);
        push_request(OP_BRAKE, 32'h7FFF_FFFF);    // cap past the signed range
        push_request(OP_BRAKE, 32'h0001_0000);    // cap lowers the target
        push_request(OP_SET_CUR, 32'h7FFF_FFFF);
        push_request(OP_TICK, 32'h00FF_FFFF);     // gap under one step: snap
        push_request(OP_SET_CUR, 32'h8000_0000);
        push_request(OP_SET_TGT, 32'h7FFF_FFFF);
        push_request(OP_TICK, 32'h0100_0000);     // gap equal to the step: no snap
        push_request(OP_TICK, 32'h0100_0000);     // zero gap with a step: snap

        // Zero acceleration: ticks never move, brake caps at zero.
        write_accel(32'd0);
        push_request(OP_SET_TGT, 32'h0005_0000);
        push_request(OP_TICK, 32'h0100_0000);
        push_request(OP_BRAKE, 32'h7FFF_FFFF);

        // Random phases: two per idle pattern, a new acceleration for each.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 24;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0:       write_accel(32'hFFFF_FFFF);
                2:       write_accel(32'd1);
                4:       write_accel($urandom_range(0, 32'h00FF_FFFF));
                default: write_accel($urandom());
            endcase
            run_segment(SEGMENT_ITEMS);
        end

        // Let the last results drain, then hold a little longer.
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
